>>> rtl/core/olb_pkg.sv
`default_nettype none
package olb_pkg;

  // Fixed field widths
  localparam int unsigned QUEUE_W = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned PASS_W  = 8;

  localparam logic [PASS_W-1:0] PASS_SAT    = 8'd255;
  localparam logic [PASS_W-1:0] MAX_PASS_RST = 8'd5;

  typedef enum logic [1:0] {
    CMD_JOIN  = 2'd0,
    CMD_ENTER = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [0:0] {
    DIR_NORTH = 1'b0,
    DIR_SOUTH = 1'b1
  } dir_t;

  // Light state and travel direction share this encoding (red means none)
  typedef enum logic [1:0] {
    LIGHT_RED   = 2'd0,
    LIGHT_NORTH = 2'd1,
    LIGHT_SOUTH = 2'd2
  } light_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       direction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         light;
    logic [QUEUE_W-1:0] north_waiting;
    logic [QUEUE_W-1:0] south_waiting;
    logic [COUNT_W-1:0] on_bridge;
    logic               event_dropped;
  } out_item_t;

  // Control from the step logic to the departure ring
  typedef struct packed {
    logic enter;
    logic tick;
  } ring_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/olb_ring.sv
`default_nettype none
module olb_ring #(
  parameter int unsigned CROSSING_TICKS = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire olb_pkg::ring_ctl_t         ctl,
  output logic [olb_pkg::COUNT_W-1:0]     gone
);
  import olb_pkg::*;

  // Slot 0 collects cars entering during the current second; the last
  // slot holds the cars that leave on the next tick.
  logic [COUNT_W-1:0] slot_r [CROSSING_TICKS];

  // Shift on tick, count up on entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(CROSSING_TICKS); i++) begin
        slot_r[i] <= '0;
      end
    end else if (ctl.tick) begin
      slot_r[0] <= '0;
      for (int i = 1; i < int'(CROSSING_TICKS); i++) begin
        slot_r[i] <= slot_r[i-1];
      end
    end else if (ctl.enter) begin
      slot_r[0] <= slot_r[0] + COUNT_W'(1);
    end
  end

  assign gone = slot_r[CROSSING_TICKS-1];

endmodule
`default_nettype wire

>>> rtl/core/olb_core.sv
`default_nettype none
module olb_core #(
  parameter int unsigned BRIDGE_CAPACITY = 16,
  parameter int unsigned QUEUE_MAX       = 255
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire olb_pkg::in_item_t          item,
  input  wire logic [olb_pkg::PASS_W-1:0] max_pass,
  input  wire logic [olb_pkg::COUNT_W-1:0] gone,
  output olb_pkg::ring_ctl_t              ring_ctl,
  output olb_pkg::out_item_t              result
);
  import olb_pkg::*;

  localparam logic [QUEUE_W-1:0] QMAX = QUEUE_W'(QUEUE_MAX);
  localparam logic [COUNT_W-1:0] CAP  = COUNT_W'(BRIDGE_CAPACITY);

  logic [QUEUE_W-1:0] nq_r, nq_nxt;
  logic [QUEUE_W-1:0] sq_r, sq_nxt;
  logic [COUNT_W-1:0] bc_r, bc_nxt;
  logic [PASS_W-1:0]  passed_r, passed_nxt;
  light_t             light_r, light_nxt;
  light_t             dir_r, dir_nxt;
  logic               dropped;
  logic [QUEUE_W-1:0] own_q;
  logic [QUEUE_W-1:0] dir_q;
  logic [QUEUE_W-1:0] light_q;
  logic [COUNT_W-1:0] bc_left;
  logic               south;

  assign south = (dir_t'(item.direction) == DIR_SOUTH);
  assign own_q = south ? sq_r : nq_r;

  // Waiting count of the side that a light code points to
  always_comb begin
    unique case (dir_r)
      LIGHT_NORTH: dir_q = nq_r;
      LIGHT_SOUTH: dir_q = sq_r;
      default:     dir_q = '0;
    endcase
    unique case (light_r)
      LIGHT_NORTH: light_q = nq_r;
      LIGHT_SOUTH: light_q = sq_r;
      default:     light_q = '0;
    endcase
  end

  // Drop departures first, floor at zero
  assign bc_left = (gone >= bc_r) ? '0 : bc_r - gone;

  // Apply one item to the state
  always_comb begin
    nq_nxt     = nq_r;
    sq_nxt     = sq_r;
    bc_nxt     = bc_r;
    passed_nxt = passed_r;
    light_nxt  = light_r;
    dir_nxt    = dir_r;
    dropped    = 1'b0;
    ring_ctl   = '0;
    if (accept) begin
      unique case (cmd_t'(item.cmd))
        CMD_JOIN: begin
          if (own_q >= QMAX) begin
            dropped = 1'b1;
          end else if (south) begin
            sq_nxt = sq_r + QUEUE_W'(1);
          end else begin
            nq_nxt = nq_r + QUEUE_W'(1);
          end
        end
        CMD_ENTER: begin
          if (own_q == '0 || bc_r >= CAP) begin
            dropped = 1'b1;
          end else begin
            if (south) begin
              sq_nxt = sq_r - QUEUE_W'(1);
            end else begin
              nq_nxt = nq_r - QUEUE_W'(1);
            end
            bc_nxt         = bc_r + COUNT_W'(1);
            ring_ctl.enter = 1'b1;
            if (passed_r < PASS_SAT) begin
              passed_nxt = passed_r + PASS_W'(1);
            end
          end
        end
        CMD_TICK: begin
          ring_ctl.tick = 1'b1;
          bc_nxt        = bc_left;
          if (light_r == LIGHT_RED) begin
            if (bc_left == '0) begin
              passed_nxt = '0;
              priority if (nq_r != '0) begin
                dir_nxt   = LIGHT_NORTH;
                light_nxt = LIGHT_NORTH;
              end else if (sq_r != '0) begin
                dir_nxt   = LIGHT_SOUTH;
                light_nxt = LIGHT_SOUTH;
              end else begin
                dir_nxt = LIGHT_RED;
              end
            end else if (dir_r != LIGHT_RED && passed_r < max_pass && dir_q != '0) begin
              light_nxt = dir_r;
            end
          end else if (light_q == '0 || passed_r >= max_pass) begin
            light_nxt = LIGHT_RED;
          end
        end
        default: begin
          // Unused command: state unchanged, nothing flagged
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_r     <= '0;
      sq_r     <= '0;
      bc_r     <= '0;
      passed_r <= '0;
      light_r  <= LIGHT_RED;
      dir_r    <= LIGHT_RED;
    end else begin
      nq_r     <= nq_nxt;
      sq_r     <= sq_nxt;
      bc_r     <= bc_nxt;
      passed_r <= passed_nxt;
      light_r  <= light_nxt;
      dir_r    <= dir_nxt;
    end
  end

  // Result shows the state after the item
  always_comb begin
    result.light         = light_nxt;
    result.north_waiting = nq_nxt;
    result.south_waiting = sq_nxt;
    result.on_bridge     = bc_nxt;
    result.event_dropped = dropped;
  end

endmodule
`default_nettype wire

>>> rtl/core/olb_out_reg.sv
`default_nettype none
module olb_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire olb_pkg::out_item_t load_data,
  output logic                    can_load,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output olb_pkg::out_item_t      out_data
);
  import olb_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  // Room when empty or when the held item leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until a new item loads
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

>>> rtl/core/one_lane_bridge_light_controller.sv
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the state update for an
// item is combinational, and the output register lets a new item in while the last is taken.
// in_ready drops only while a result is held and out_ready is low.
// Reset (synchronous, rst_n low): queues, bridge count, pass count and the
// departure ring clear, lights go red, max_pass returns to 5.
`default_nettype none
module one_lane_bridge_light_controller #(
  parameter int unsigned CROSSING_TICKS  = 5,
  parameter int unsigned BRIDGE_CAPACITY = 16,
  parameter int unsigned QUEUE_MAX       = 255
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire olb_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output olb_pkg::out_item_t              out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [olb_pkg::PASS_W-1:0] cfg_data
);
  import olb_pkg::*;

  logic               accept;
  logic [PASS_W-1:0]  max_pass_r;
  logic [COUNT_W-1:0] gone;
  ring_ctl_t          ring_ctl;
  out_item_t          result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pass_r <= MAX_PASS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_pass_r <= cfg_data;
    end
  end

  olb_core #(
    .BRIDGE_CAPACITY (BRIDGE_CAPACITY),
    .QUEUE_MAX       (QUEUE_MAX)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .max_pass (max_pass_r),
    .gone     (gone),
    .ring_ctl (ring_ctl),
    .result   (result)
  );

  olb_ring #(
    .CROSSING_TICKS (CROSSING_TICKS)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .gone  (gone)
  );

  olb_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (result),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/core/olb_checker.sv
`default_nettype none
module olb_checker #(
  parameter int unsigned BRIDGE_CAPACITY = 16
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire olb_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire olb_pkg::out_item_t out_data
);
  import olb_pkg::*;

  // Every accepted item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted item");

  // A tick never flags a dropped event
  a_tick_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == CMD_TICK) |=> !out_data.event_dropped)
    else $error("tick flagged as dropped");

  // Occupancy stays within capacity
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.on_bridge <= COUNT_W'(BRIDGE_CAPACITY)))
    else $error("bridge occupancy above capacity");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind one_lane_bridge_light_controller olb_checker #(
  .BRIDGE_CAPACITY (BRIDGE_CAPACITY)
) u_olb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
